// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque: command and status codes, word widths
// and the input/result word structs. No dependencies.
package cdq_pkg;

  localparam int WORD_W    = 32;
  localparam int COUNT_W   = 4;
  localparam int DEPTH_DEF = 8;

  // Command codes; unused codes act as a query
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] popped;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] rear_word;
  } out_word_t;

endpackage

// ----- rtl/cdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/circular_deque.sv -----
// Circular deque top level: control, index registers, front/rear word cache
// and output buffering around one cdq_ram. Depends on cdq_pkg and cdq_ram.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one command word:
//   push front, push back, pop front, pop back or query. Output channel
//   (out_valid, out_stall, out_data) returns exactly one result word per
//   command: status, popped word, count, and the words at front and rear.
//   A word moves at a rising edge where valid is high and stall is low.
// Results:
//   Pushes, queries and rejected pops put their result in the output
//   register, or in the skid register if it is stalled, at the accept
//   edge. A successful pop waits in S_READ, with in_stall high, for the
//   storage RAM's registered read of the new front or rear word.
// Stalls:
//   A result that cannot leave waits in the output register; one more
//   result can wait in a skid register, after which in_stall rises.
// Reset:
//   rst (synchronous, active high) empties the deque; RAM contents are
//   left as they are and are never read before being written.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                   state, state_next;
  logic [AW-1:0]            head, head_next;
  logic [AW-1:0]            tail, tail_next;
  logic [CW-1:0]            cnt, cnt_next;
  logic signed [WORD_W-1:0] front_q, front_next;
  logic signed [WORD_W-1:0] rear_q, rear_next;
  logic signed [WORD_W-1:0] pend_popped;
  logic                     pend_front;
  logic                     hold_valid;
  out_word_t                hold_data;
  out_word_t                res_word;
  logic                     res_valid;
  logic                     acc;
  logic                     out_free;
  logic                     full;
  logic                     empty;
  logic [AW-1:0]            head_inc, head_dec, tail_inc, tail_dec, tail_dec2;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [AW-1:0]            ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
  endfunction

  // Handshake and neighbor indices
  assign in_stall  = (state != S_IDLE) || hold_valid;
  assign acc       = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign full      = (cnt == CW'(DEPTH));
  assign empty     = (cnt == '0);
  assign head_inc  = wrap_inc(head);
  assign head_dec  = wrap_dec(head);
  assign tail_inc  = wrap_inc(tail);
  assign tail_dec  = wrap_dec(tail);
  assign tail_dec2 = wrap_dec(tail_dec);

  // Write pushes; read the word that becomes the new end after a pop
  assign ram_we    = acc && !full &&
                     (in_data.cmd == CMD_PUSH_FRONT || in_data.cmd == CMD_PUSH_BACK);
  assign ram_waddr = (in_data.cmd == CMD_PUSH_FRONT) ? head_dec : tail;
  assign ram_raddr = (in_data.cmd == CMD_POP_FRONT) ? head_inc : tail_dec2;

  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_data.value),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Next-state and result word
  always_comb begin
    state_next = state;
    head_next  = head;
    tail_next  = tail;
    cnt_next   = cnt;
    front_next = front_q;
    rear_next  = rear_q;
    res_valid  = 1'b0;
    res_word   = '{status: ST_OK, popped: '0, count: COUNT_W'(cnt),
                   front_word: front_q, rear_word: rear_q};
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (in_data.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              res_valid = 1'b1;
              if (full) begin
                res_word.status = ST_OVERFLOW;
              end else begin
                cnt_next = cnt + 1'b1;
                if (in_data.cmd == CMD_PUSH_FRONT) begin
                  head_next  = head_dec;
                  front_next = in_data.value;
                  if (empty) begin
                    rear_next = in_data.value;
                  end
                end else begin
                  tail_next = tail_inc;
                  rear_next = in_data.value;
                  if (empty) begin
                    front_next = in_data.value;
                  end
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (empty) begin
                res_valid       = 1'b1;
                res_word.status = ST_UNDERFLOW;
              end else begin
                cnt_next   = cnt - 1'b1;
                state_next = S_READ;
                if (in_data.cmd == CMD_POP_FRONT) begin
                  head_next = head_inc;
                end else begin
                  tail_next = tail_dec;
                end
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
          res_word.count      = COUNT_W'(cnt_next);
          res_word.front_word = front_next;
          res_word.rear_word  = rear_next;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
        res_valid  = 1'b1;
        if (cnt == '0) begin
          front_next = '0;
          rear_next  = '0;
        end else if (pend_front) begin
          front_next = ram_rdata;
        end else begin
          rear_next = ram_rdata;
        end
        res_word.popped     = pend_popped;
        res_word.front_word = front_next;
        res_word.rear_word  = rear_next;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, indices, end-word cache and output buffering
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      cnt        <= '0;
      front_q    <= '0;
      rear_q     <= '0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      tail    <= tail_next;
      cnt     <= cnt_next;
      front_q <= front_next;
      rear_q  <= rear_next;
      // advance the skid word, place a new result, or drop a taken word
      if (hold_valid && out_free) begin
        out_data   <= hold_data;
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else if (res_valid && out_free) begin
        out_data  <= res_word;
        out_valid <= 1'b1;
      end else if (res_valid) begin
        hold_data  <= res_word;
        hold_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    // capture the popped word from the cache at accept
    if (acc) begin
      pend_front  <= (in_data.cmd == CMD_POP_FRONT);
      pend_popped <= (in_data.cmd == CMD_POP_FRONT) ? front_q : rear_q;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count exceeds depth");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("skid word held while output register is empty");

  a_empty_cache_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cnt == '0) |-> (front_q == '0 && rear_q == '0))
    else $error("end words not zero on empty deque");

  a_pop_one_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_IDLE && !hold_valid || out_valid))
    else $error("pop read did not complete with a result");
`endif

endmodule
